// ===== rtl/emsi_data_packet_receiver_defines.svh =====
// Assertion macros for the EMSI data packet body receiver.
// Used by the port checker; expects clk and rst_n in the calling scope.
`ifndef EMSI_DATA_PACKET_RECEIVER_DEFINES_SVH
`define EMSI_DATA_PACKET_RECEIVER_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define EMSI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, disabled during reset.
`define EMSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/emsi_pkg.sv =====
// Shared types, codes and functions for the EMSI data packet body receiver.
// No dependencies; imported by every module of the block.
package emsi_pkg;

  // Input transaction: a received byte or a read timeout.
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  // Result transaction: a payload byte or an end-of-packet verdict.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic [15:0] packet_length;
  } out_t;

  // Classified item held in the queue between front and back.
  typedef struct packed {
    logic       timeout;
    logic [7:0] rx_byte;
    logic [3:0] nibble;
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic       CMD_TIMEOUT = 1'b1;
  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;
  localparam logic [1:0] VERDICT_GOOD     = 2'd0;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
  localparam logic [1:0] VERDICT_TIMEOUT  = 2'd2;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  CHAR_ZERO = 8'd48;
  localparam logic [7:0]  CHAR_LC_A = 8'd97;
  localparam logic [7:0]  CHAR_LC_Z = 8'd122;
  localparam logic [7:0]  CASE_GAP  = 8'd32;
  localparam logic [7:0]  ALPHA_GAP = 8'd7;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Case-insensitive hex digit value; any character gives some nibble.
  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [7:0] up;
    logic [7:0] v;
    up = b;
    if (up >= CHAR_LC_A && up <= CHAR_LC_Z) begin
      up = up - CASE_GAP;
    end
    v = up - CHAR_ZERO;
    if (up >= CHAR_ZERO && v > 8'd9) begin
      v = v - ALPHA_GAP;
    end
    if (up < CHAR_ZERO) begin
      v = up;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/emsi_fifo.sv =====
// Short queue of classified items between the front and the back.
// Depends on emsi_pkg for the item type and the depth.
module emsi_fifo
  import emsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_data,
  input  logic      pop,
  output item_t     head,
  output q_status_t status
);

  item_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  // Status flags from the fill count.
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == (QAW+1)'(QDEPTH));
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/emsi_front.sv =====
// Front end: accepts input transactions and classifies each byte.
// Depends on emsi_pkg for the transaction types and the hex fold.
module emsi_front
  import emsi_pkg::*;
(
  input  logic      in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  input  q_status_t q_status,
  output logic      push,
  output item_t     push_data
);

  // Accept whenever the queue has room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classification: timeout flag and the digit value of the byte.
  always_comb begin
    push_data.timeout = (in_data.command == CMD_TIMEOUT);
    push_data.rx_byte = in_data.rx_byte;
    push_data.nibble  = hex_nibble(in_data.rx_byte);
  end

endmodule

// ===== rtl/emsi_back.sv =====
// Back end: packet sequencer, running CRC and the result register.
// Depends on emsi_pkg for the item and result types and the CRC function.
module emsi_back
  import emsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  q_status_t   q_status,
  input  item_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_DATA,
    PH_CRC,
    PH_TRAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  digit_cnt_r, digit_cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] sender_r, sender_nxt;
  logic [15:0] seed_r;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;
  logic        emit;
  logic [15:0] crc_base;
  logic [15:0] seen_inc;

  // Take one item per cycle while the result register can move.
  assign pop       = !q_status.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign crc_base  = (digit_cnt_r == '0) ? seed_r : crc_r;
  assign seen_inc  = seen_r + 16'd1;

  // Seed register; the first length digit of a packet picks it up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // Per-item packet step.
  always_comb begin
    phase_nxt     = phase_r;
    digit_cnt_nxt = digit_cnt_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    crc_nxt       = crc_r;
    sender_nxt    = sender_r;
    emit          = 1'b0;
    out_nxt       = out_r;
    if (pop) begin
      if (phase_r == PH_TRAIL || head.timeout) begin
        // Verdict ends the packet and restarts all state.
        emit                  = 1'b1;
        out_nxt.kind          = KIND_VERDICT;
        out_nxt.payload_byte  = '0;
        out_nxt.packet_length = len_r;
        if (phase_r == PH_TRAIL) begin
          out_nxt.verdict = (crc_r == sender_r) ? VERDICT_GOOD : VERDICT_MISMATCH;
        end else begin
          out_nxt.verdict = VERDICT_TIMEOUT;
        end
        phase_nxt     = PH_LEN;
        digit_cnt_nxt = '0;
        len_nxt       = '0;
        seen_nxt      = '0;
        crc_nxt       = seed_r;
        sender_nxt    = '0;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            crc_nxt       = crc_byte(crc_base, head.rx_byte);
            len_nxt       = {len_r[11:0], head.nibble};
            digit_cnt_nxt = digit_cnt_r + 2'd1;
            if (digit_cnt_r == 2'd3) begin
              phase_nxt = (len_nxt == '0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            crc_nxt  = crc_byte(crc_r, head.rx_byte);
            seen_nxt = seen_inc;
            if (seen_inc >= len_r) begin
              phase_nxt = PH_CRC;
            end
            emit                  = 1'b1;
            out_nxt.kind          = KIND_DATA;
            out_nxt.payload_byte  = head.rx_byte;
            out_nxt.verdict       = VERDICT_GOOD;
            out_nxt.packet_length = len_r;
          end
          PH_CRC: begin
            sender_nxt    = {sender_r[11:0], head.nibble};
            digit_cnt_nxt = digit_cnt_r + 2'd1;
            if (digit_cnt_r == 2'd3) begin
              phase_nxt = PH_TRAIL;
            end
          end
          default: begin
            phase_nxt = PH_LEN;
          end
        endcase
      end
    end
    // Result register: load on emit, drain when taken.
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      digit_cnt_r <= '0;
      len_r       <= '0;
      seen_r      <= '0;
      crc_r       <= '0;
      sender_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      crc_r       <= crc_nxt;
      sender_r    <= sender_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/emsi_data_packet_receiver.sv =====
// EMSI data packet body receiver with CRC-16/XMODEM check.
// Usage:
//   in_valid/in_stall/in_data carry one transaction per received byte or
//   read timeout, starting with the four length digits after the header.
//   out_valid/out_stall/out_data give one transaction per payload byte and
//   one verdict transaction (good, mismatch or timeout) at packet end.
//   cfg_wr_en/cfg_wr_data load the CRC seed; write it between packets.
// Timing:
//   An accepted byte enters a four-entry queue; the sequencer takes one
//   item per cycle from it while the result register can move, and each
//   result passes through the queue entry and then the result register.
//   Throughput is one item per cycle while out_stall is low.
// Stall:
//   When the receiver stalls, the result register holds, the sequencer
//   stops, and the queue absorbs up to four more input transactions before
//   in_stall rises.
// Reset:
//   Synchronous active-low rst_n empties the queue, clears the seed to zero
//   and waits for the length digits of a new packet.
// Depends on emsi_pkg, emsi_front, emsi_fifo and emsi_back.
module emsi_data_packet_receiver
  import emsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  item_t     push_data;
  item_t     head;

  // Front end: accept and classify.
  emsi_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between the two halves.
  emsi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Back end: sequencer, CRC and result register.
  emsi_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/emsi_chk.sv =====
// Port checker for the EMSI data packet body receiver, with its bind.
// Depends on emsi_pkg and emsi_data_packet_receiver_defines.svh.
`include "emsi_data_packet_receiver_defines.svh"

module emsi_chk
  import emsi_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result transaction holds.
  `EMSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_data), "stalled result changed")

  // Verdict codes stay in range.
  `EMSI_ASSERT_SAME(a_verdict_range, out_valid, out_data.verdict <= VERDICT_TIMEOUT,
                    "verdict code out of range")

  // Payload transactions carry a zero verdict.
  `EMSI_ASSERT_SAME(a_data_verdict, out_valid && out_data.kind == KIND_DATA,
                    out_data.verdict == VERDICT_GOOD, "payload with verdict")

  // Verdict transactions carry a zero payload byte.
  `EMSI_ASSERT_SAME(a_verdict_byte, out_valid && out_data.kind == KIND_VERDICT,
                    out_data.payload_byte == 8'd0, "verdict with payload byte")

endmodule

bind emsi_data_packet_receiver emsi_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
